/* src/kmb_pkg.sv */
package kmb_pkg;

	// Default table depth
	localparam int ENTRIES_DEF = 8;

	// Field widths
	localparam int KEY_W  = 8;
	localparam int VAL_W  = 32;
	localparam int WORD_W = KEY_W + VAL_W;

	// Bus write key that selects the transmit key
	localparam logic [KEY_W-1:0] TX_SELECT_KEY = 8'hFF;

	// Request kinds carried in tuser
	typedef enum logic [1:0] {
		KIND_WRITE = 2'd0,
		KIND_READ  = 2'd1,
		KIND_ADD   = 2'd2,
		KIND_QUERY = 2'd3
	} kind_t;

endpackage

/* src/kmb_ram.sv */
module kmb_ram #(
	parameter int WIDTH = kmb_pkg::WORD_W,
	parameter int DEPTH = kmb_pkg::ENTRIES_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* src/keyed_mailbox_bus_slave_top.sv */
// Transmit key select and host add go from the accepted request to the result register and on
// to the output register; bus write, bus read and host query first scan the table one entry a
// cycle and stop at the first hit or after the last entry.
// One request at a time, set by the single key comparator and the table read port: the next is
// taken once the last result enters the output register, so a stalled result holds it off.
// Reset (arst_n low, asynchronous): valid bits, ring pointers, transmit key and error clear;
// table contents are left as they are and are never matched until written.
module keyed_mailbox_bus_slave_top #(
	parameter int ENTRIES = kmb_pkg::ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// request side
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // [7:0] key, [39:8] value
	input  logic [1:0]  s_tuser,  // [1:0] kind
	// result side
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // [7:0] out_key, [39:8] out_value
	output logic [1:0]  m_tuser   // [0] found, [1] error
);

	import kmb_pkg::*;

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_RESP = 3'b100
	} state_t;

	state_t state_q;

	logic [IW-1:0]      idx_q;
	logic [IW-1:0]      recv_pos_q;
	logic [IW-1:0]      send_pos_q;
	logic [ENTRIES-1:0] recv_valid_q;
	logic [ENTRIES-1:0] send_valid_q;
	logic [KEY_W-1:0]   transmit_key_q;
	logic               last_error_q;
	logic               m_valid_q;
	kind_t              kind_q;

	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] value_q;
	logic [KEY_W-1:0] look_key_q;
	logic [KEY_W-1:0] res_key_q;
	logic [VAL_W-1:0] res_val_q;
	logic             res_found_q;
	logic             res_err_q;
	logic [KEY_W-1:0] out_key_q;
	logic [VAL_W-1:0] out_val_q;
	logic             out_found_q;
	logic             out_err_q;

	// Request fields
	kind_t            kind_in;
	logic [KEY_W-1:0] key_in;
	logic [VAL_W-1:0] value_in;
	logic             accept;

	assign kind_in  = kind_t'(s_tuser[1:0]);
	assign key_in   = s_tdata[KEY_W-1:0];
	assign value_in = s_tdata[WORD_W-1:KEY_W];
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	// Ring pointers advance before they are written
	logic [IW-1:0] recv_next;
	logic [IW-1:0] send_next;

	assign recv_next = (recv_pos_q == LAST) ? '0 : recv_pos_q + IW'(1);
	assign send_next = (send_pos_q == LAST) ? '0 : send_pos_q + IW'(1);

	// Table memories, word is {key, value}
	logic [IW-1:0]     rd_addr;
	logic [WORD_W-1:0] recv_rdata;
	logic [WORD_W-1:0] send_rdata;
	logic              recv_we;
	logic [IW-1:0]     recv_waddr;
	logic              send_we;

	// Prefetch the entry after the one being compared; entry 0 on accept
	assign rd_addr = (state_q == ST_SCAN && idx_q != LAST) ? idx_q + IW'(1) : '0;

	kmb_ram #(
		.WIDTH(WORD_W),
		.DEPTH(ENTRIES)
	) u_recv_ram (
		.clk  (clk),
		.we   (recv_we),
		.waddr(recv_waddr),
		.wdata({key_q, value_q}),
		.raddr(rd_addr),
		.rdata(recv_rdata)
	);

	kmb_ram #(
		.WIDTH(WORD_W),
		.DEPTH(ENTRIES)
	) u_send_ram (
		.clk  (clk),
		.we   (send_we),
		.waddr(send_next),
		.wdata({key_in, value_in}),
		.raddr(rd_addr),
		.rdata(send_rdata)
	);

	// Shared key comparator over the selected table
	logic [WORD_W-1:0] tbl_word;
	logic              tbl_valid;
	logic [VAL_W-1:0]  tbl_val;
	logic              hit;
	logic              scan_done;

	assign tbl_word  = (kind_q == KIND_READ) ? send_rdata : recv_rdata;
	assign tbl_valid = (kind_q == KIND_READ) ? send_valid_q[idx_q] : recv_valid_q[idx_q];
	assign tbl_val   = tbl_word[VAL_W-1:0];
	assign hit       = tbl_valid && (tbl_word[WORD_W-1:VAL_W] == look_key_q);
	assign scan_done = (state_q == ST_SCAN) && (hit || idx_q == LAST);

	assign recv_we    = scan_done && (kind_q == KIND_WRITE);
	assign recv_waddr = hit ? idx_q : recv_next;
	assign send_we    = accept && (kind_in == KIND_ADD);

	// Output register load
	logic out_load;

	assign out_load = (state_q == ST_RESP) && (!m_valid_q || m_tready);

	// Sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			idx_q          <= '0;
			recv_pos_q     <= '0;
			send_pos_q     <= '0;
			recv_valid_q   <= '0;
			send_valid_q   <= '0;
			transmit_key_q <= '0;
			last_error_q   <= 1'b0;
			m_valid_q      <= 1'b0;
			kind_q         <= KIND_WRITE;
		end else begin
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						kind_q <= kind_in;
						idx_q  <= '0;
						unique case (kind_in) inside
							KIND_WRITE: begin
								if (key_in == TX_SELECT_KEY) begin
									transmit_key_q <= value_in[KEY_W-1:0];
									state_q        <= ST_RESP;
								end else begin
									state_q <= ST_SCAN;
								end
							end
							KIND_ADD: begin
								send_pos_q              <= send_next;
								send_valid_q[send_next] <= 1'b1;
								state_q                 <= ST_RESP;
							end
							KIND_READ, KIND_QUERY: begin
								state_q <= ST_SCAN;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_SCAN: begin
					if (scan_done) begin
						state_q <= ST_RESP;
						if (kind_q == KIND_WRITE) begin
							recv_valid_q[recv_waddr] <= 1'b1;
							last_error_q             <= 1'b0;
							if (!hit) begin
								recv_pos_q <= recv_next;
							end
						end else if (kind_q == KIND_READ) begin
							last_error_q <= !hit;
						end
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end
				ST_RESP: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Request and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q       <= key_in;
			value_q     <= value_in;
			look_key_q  <= (kind_in == KIND_READ) ? transmit_key_q : key_in;
			// host add reports its own entry, the rest start from zero
			res_key_q   <= (kind_in == KIND_ADD) ? key_in : '0;
			res_val_q   <= (kind_in == KIND_ADD) ? value_in : '0;
			res_found_q <= 1'b0;
			res_err_q   <= last_error_q;
		end
		if (scan_done) begin
			case (kind_q)
				KIND_WRITE: begin
					res_key_q   <= key_q;
					res_val_q   <= value_q;
					res_found_q <= hit;
					res_err_q   <= 1'b0;
				end
				KIND_READ: begin
					res_key_q   <= hit ? look_key_q : '0;
					res_val_q   <= hit ? tbl_val : '0;
					res_found_q <= hit;
					res_err_q   <= !hit;
				end
				default: begin
					res_key_q   <= hit ? key_q : '0;
					res_val_q   <= hit ? tbl_val : '0;
					res_found_q <= hit;
					res_err_q   <= last_error_q;
				end
			endcase
		end
		if (out_load) begin
			out_key_q   <= res_key_q;
			out_val_q   <= res_val_q;
			out_found_q <= res_found_q;
			out_err_q   <= res_err_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {out_val_q, out_key_q};
	assign m_tuser  = {out_err_q, out_found_q};

	// Checks
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (idx_q <= LAST))
		else $error("scan index past last entry");

	a_leave_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != ST_IDLE))
		else $error("accepted request did not start work");

	a_load_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_valid_q) |-> $past(state_q == ST_RESP))
		else $error("result shown without a finished request");

	a_write_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		recv_we |=> recv_valid_q[$past(recv_waddr)])
		else $error("receive entry written but not marked valid");

endmodule

/* bench/keyed_mailbox_bus_slave_top_test.sv */
`timescale 1ns / 1ps

module keyed_mailbox_bus_slave_top_test;

	import kmb_pkg::*;

	localparam int ENTRIES    = ENTRIES_DEF;
	localparam int HOLD_LEN   = 300;
	localparam int RAND_ITEMS = 1300;
	localparam int PHASES     = 4;

	// One expected result of the mailbox
	typedef struct {
		logic [KEY_W-1:0] out_key;
		logic [VAL_W-1:0] out_value;
		logic             found;
		logic             error;
	} mbox_result_t;

	// Mailbox predictor plus queue of pending results
	class mbox_scoreboard;
		logic [KEY_W-1:0] rx_key [ENTRIES];
		logic [VAL_W-1:0] rx_val [ENTRIES];
		bit               rx_vld [ENTRIES];
		logic [KEY_W-1:0] tx_key [ENTRIES];
		logic [VAL_W-1:0] tx_val [ENTRIES];
		bit               tx_vld [ENTRIES];
		int               rx_pos;
		int               tx_pos;
		logic [KEY_W-1:0] sel_key;
		logic             err_flag;
		mbox_result_t     pending_q[$];
		int               mismatches;
		int               requests;
		int               hits;
		int               err_results;
		int               kind_cnt [4];

		function new();
			foreach (rx_vld[i]) begin
				rx_vld[i] = 0;
				tx_vld[i] = 0;
			end
			rx_pos = 0;
			tx_pos = 0;
			sel_key = '0;
			err_flag = 1'b0;
			mismatches = 0;
			requests = 0;
			hits = 0;
			err_results = 0;
			foreach (kind_cnt[i]) kind_cnt[i] = 0;
		endfunction

		// Lowest valid entry holding k, ENTRIES on a miss
		function int find_rx(logic [KEY_W-1:0] k);
			for (int i = 0; i < ENTRIES; i++) begin
				if (rx_vld[i] && rx_key[i] == k) return i;
			end
			return ENTRIES;
		endfunction

		function int find_tx(logic [KEY_W-1:0] k);
			for (int i = 0; i < ENTRIES; i++) begin
				if (tx_vld[i] && tx_key[i] == k) return i;
			end
			return ENTRIES;
		endfunction

		function int ring_next(int p);
			return (p + 1 >= ENTRIES) ? 0 : p + 1;
		endfunction

		// Update the mailbox state for one accepted request and queue its result
		function void note_request(kind_t kind, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
			mbox_result_t r;
			int idx;
			r = '{default: '0};
			requests++;
			kind_cnt[kind]++;
			case (kind)
				KIND_WRITE: begin
					if (key == TX_SELECT_KEY) begin
						sel_key = value[KEY_W-1:0];
					end else begin
						idx = find_rx(key);
						if (idx < ENTRIES) begin
							r.found = 1'b1;
						end else begin
							rx_pos = ring_next(rx_pos);
							idx = rx_pos;
						end
						rx_key[idx] = key;
						rx_val[idx] = value;
						rx_vld[idx] = 1;
						err_flag = 1'b0;
						r.out_key = key;
						r.out_value = value;
					end
				end
				KIND_READ: begin
					idx = find_tx(sel_key);
					if (idx < ENTRIES) begin
						r.out_key = sel_key;
						r.out_value = tx_val[idx];
						r.found = 1'b1;
						err_flag = 1'b0;
					end else begin
						err_flag = 1'b1;
					end
				end
				KIND_ADD: begin
					tx_pos = ring_next(tx_pos);
					tx_key[tx_pos] = key;
					tx_val[tx_pos] = value;
					tx_vld[tx_pos] = 1;
					r.out_key = key;
					r.out_value = value;
				end
				default: begin
					idx = find_rx(key);
					if (idx < ENTRIES) begin
						r.out_key = key;
						r.out_value = rx_val[idx];
						r.found = 1'b1;
					end
				end
			endcase
			r.error = err_flag;
			if (r.found) hits++;
			if (r.error) err_results++;
			pending_q.push_back(r);
		endfunction

		// Compare one accepted result with the oldest pending one
		function void check_result(logic [WORD_W-1:0] data, logic [1:0] user);
			mbox_result_t r;
			if (pending_q.size() == 0) begin
				$error("unexpected result: tdata %0h tuser %0h", data, user);
				mismatches++;
				return;
			end
			r = pending_q.pop_front();
			if (data[KEY_W-1:0] !== r.out_key) begin
				$error("out_key expected %0h got %0h", r.out_key, data[KEY_W-1:0]);
				mismatches++;
			end
			if (data[WORD_W-1:KEY_W] !== r.out_value) begin
				$error("out_value expected %0h got %0h", r.out_value, data[WORD_W-1:KEY_W]);
				mismatches++;
			end
			if (user[0] !== r.found) begin
				$error("found expected %0b got %0b", r.found, user[0]);
				mismatches++;
			end
			if (user[1] !== r.error) begin
				$error("error expected %0b got %0b", r.error, user[1]);
				mismatches++;
			end
		endfunction

		function int pending();
			return pending_q.size();
		endfunction
	endclass

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [WORD_W-1:0] s_tdata  = '0;
	logic [1:0]        s_tuser  = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [WORD_W-1:0] m_tdata;
	logic [1:0]        m_tuser;

	int idle_pct  = 0;
	int stall_pct = 0;
	bit rx_hold   = 1'b0;
	bit hold_go   = 1'b0;

	mbox_scoreboard sb = new();

	keyed_mailbox_bus_slave_top #(
		.ENTRIES(ENTRIES)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	always #4 clk = ~clk;

	// Result side: random stalls, or a long hold while the sender keeps offering
	always @(posedge clk) begin
		m_tready <= rx_hold ? 1'b0 : ($urandom_range(99) >= stall_pct);
	end

	// Long receiver hold-off, counted here
	initial begin
		wait (hold_go);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (HOLD_LEN) @(posedge clk);
		rx_hold <= 1'b0;
	end

	// Result monitor
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
	end

	// Offer one request, with random idle cycles ahead of it
	task automatic send_req(kind_t kind, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {value, key};
		s_tuser  <= kind;
		do @(posedge clk); while (!s_tready);
		sb.note_request(kind, key, value);
	endtask

	// Keys mostly from a small pool so lookups hit and duplicates arise
	function automatic logic [KEY_W-1:0] pick_key();
		int sel;
		sel = $urandom_range(99);
		if (sel < 70) return KEY_W'($urandom_range(11));
		if (sel < 78) return 8'hFE;
		return KEY_W'($urandom_range(255));
	endfunction

	task automatic send_random();
		int sel;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
		sel = $urandom_range(99);
		key = pick_key();
		value = $urandom;
		if (sel < 30) begin
			// ordinary bus write; 255 would select instead
			if (key == TX_SELECT_KEY) key = 8'h00;
			send_req(KIND_WRITE, key, value);
		end else if (sel < 40) begin
			// transmit key select, usually onto a pool key
			if ($urandom_range(99) < 80) value[KEY_W-1:0] = pick_key();
			send_req(KIND_WRITE, TX_SELECT_KEY, value);
		end else if (sel < 60) begin
			send_req(KIND_READ, key, value);
		end else if (sel < 80) begin
			send_req(KIND_ADD, key, value);
		end else begin
			send_req(KIND_QUERY, key, value);
		end
	endtask

	// Fixed run limit
	initial begin
		#5_000_000;
		$display("keyed_mailbox_bus_slave_top_test: FAIL");
		$finish;
	end

	// Main sequence
	initial begin
		int idle_tab  [PHASES] = '{0, 81, 0, 20};
		int stall_tab [PHASES] = '{0, 0, 81, 20};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty tables, sticky error, select, duplicates
		send_req(KIND_READ, 8'h00, 32'h0);
		send_req(KIND_QUERY, 8'h00, 32'h0);
		send_req(KIND_ADD, 8'h00, 32'h0);
		send_req(KIND_WRITE, TX_SELECT_KEY, 32'hFFFF_FF00);
		send_req(KIND_READ, 8'hFF, 32'hFFFF_FFFF);
		send_req(KIND_WRITE, TX_SELECT_KEY, 32'h0000_00AB);
		send_req(KIND_READ, 8'h00, 32'h0);
		send_req(KIND_ADD, 8'hAB, 32'hFFFF_FFFF);
		send_req(KIND_ADD, 8'hAB, 32'h1234_5678);
		send_req(KIND_READ, 8'h00, 32'h0);
		send_req(KIND_WRITE, 8'h00, 32'h0);
		send_req(KIND_WRITE, 8'hFE, 32'hFFFF_FFFF);
		send_req(KIND_WRITE, 8'h00, 32'hA5A5_A5A5);
		send_req(KIND_QUERY, 8'h00, 32'h0);
		send_req(KIND_QUERY, 8'hFE, 32'h0);
		send_req(KIND_QUERY, 8'hFF, 32'h0);
		send_req(KIND_ADD, 8'hFF, 32'h0000_0001);
		send_req(KIND_WRITE, TX_SELECT_KEY, 32'h0000_00FF);
		send_req(KIND_READ, 8'h00, 32'h0);
		// fill the receive ring until it wraps over the first entries
		for (int i = 0; i < ENTRIES - 1; i++) begin
			send_req(KIND_WRITE, KEY_W'(8'h10 + i), $urandom);
		end
		send_req(KIND_QUERY, 8'h00, 32'h0);

		// Random phases with different idle and stall patterns
		for (int p = 0; p < PHASES; p++) begin
			idle_pct  <= idle_tab[p];
			stall_pct <= stall_tab[p];
			if (p == 0) hold_go <= 1'b1;
			for (int n = 0; n < RAND_ITEMS / PHASES; n++) send_random();
		end
		s_tvalid <= 1'b0;

		// Drain, then allow the block's own latency
		while (sb.pending() != 0) @(posedge clk);
		repeat (ENTRIES + 8) @(posedge clk);

		$display("covered %0d requests: %0d writes/selects, %0d reads, %0d adds, %0d queries",
			sb.requests, sb.kind_cnt[KIND_WRITE], sb.kind_cnt[KIND_READ],
			sb.kind_cnt[KIND_ADD], sb.kind_cnt[KIND_QUERY]);
		$display("lookup hits %0d, results with not-found error %0d", sb.hits, sb.err_results);
		if (sb.mismatches == 0) begin
			$display("keyed_mailbox_bus_slave_top_test: PASS");
		end else begin
			$display("keyed_mailbox_bus_slave_top_test: FAIL");
		end
		$finish;
	end

endmodule

/* sim.f */
src/kmb_pkg.sv
src/kmb_ram.sv
src/keyed_mailbox_bus_slave_top.sv
bench/keyed_mailbox_bus_slave_top_test.sv
